FILE: hdl/a64eu_pkg.sv
`timescale 1ns / 1ps
// shared types and codes for the a64 execute unit
// no dependencies; imported by front, queue, back and top level
package a64eu_pkg;

	// instruction classes on the input beat
	localparam logic [1:0] KIND_DPI = 2'd0;
	localparam logic [1:0] KIND_DPR = 2'd1;
	localparam logic [1:0] KIND_BR  = 2'd2;
	localparam logic [1:0] KIND_NOP = 2'd3;

	// encoding fields
	localparam logic [2:0] OPI_ARITH = 3'h2;
	localparam logic [2:0] OPI_WIDE  = 3'h5;
	localparam logic [5:0] BR_UNCOND = 6'h05;
	localparam logic [5:0] BR_REG    = 6'h35;
	localparam logic [5:0] BR_COND   = 6'h15;
	localparam logic [3:0] MUL_OPR   = 4'h8;
	localparam logic [4:0] ZERO_REG  = 5'h1f;

	// decoded operation codes
	localparam logic [3:0] OP_NOP   = 4'd0;
	localparam logic [3:0] OP_ADDI  = 4'd1;
	localparam logic [3:0] OP_MOVW  = 4'd2;
	localparam logic [3:0] OP_LOGR  = 4'd3;
	localparam logic [3:0] OP_ADDR  = 4'd4;
	localparam logic [3:0] OP_MUL   = 4'd5;
	localparam logic [3:0] OP_B     = 4'd6;
	localparam logic [3:0] OP_BR    = 4'd7;
	localparam logic [3:0] OP_BCOND = 4'd8;
	localparam logic [3:0] OP_FAULT = 4'd9;

	// decoded instruction handed from front to back
	typedef struct packed {
		logic [3:0]  op;
		logic [31:0] iw;
		logic [4:0]  ra0;
		logic [4:0]  ra1;
	} dec_t;

endpackage

FILE: hdl/a64eu_front.sv
`timescale 1ns / 1ps
// front end: input handshake and instruction classification
// depends on a64eu_pkg
module a64eu_front import a64eu_pkg::*; (
	input  logic        valid,
	input  logic [1:0]  kind,
	input  logic [31:0] instruction_word,
	input  logic        q_full,
	output logic        stall,
	output logic        push,
	output dec_t        dec
);

	logic [31:0] iw;
	logic        sf;
	logic [1:0]  opc;

	assign iw    = instruction_word;
	assign sf    = iw[31];
	assign opc   = iw[30:29];
	assign stall = q_full;
	assign push  = valid && !q_full;

	always_comb begin
		dec.iw  = iw;
		dec.ra1 = iw[20:16];
		dec.ra0 = iw[9:5];
		dec.op  = OP_FAULT;
		unique case (kind)
			KIND_DPI: begin
				if (iw[25:23] == OPI_ARITH) begin
					dec.op = OP_ADDI;
				end else if (iw[25:23] == OPI_WIDE) begin
					// movk reads its own destination
					dec.ra0 = iw[4:0];
					if (!(opc == 2'b01 || (!sf && iw[22]))) begin
						dec.op = OP_MOVW;
					end
				end
			end
			KIND_DPR: begin
				if (!iw[28]) begin
					if (!((!sf && iw[15]) || (iw[24] && iw[21]) ||
						(iw[24] && iw[23:22] == 2'b11))) begin
						dec.op = iw[24] ? OP_ADDR : OP_LOGR;
					end
				end else if (iw[24:21] == MUL_OPR) begin
					dec.op = OP_MUL;
				end
			end
			KIND_BR: begin
				if (iw[31:26] == BR_UNCOND) begin
					dec.op = OP_B;
				end else if (iw[31:26] == BR_REG) begin
					dec.op = OP_BR;
				end else if (iw[31:26] == BR_COND) begin
					dec.op = OP_BCOND;
				end
			end
			default: begin
				dec.op = OP_NOP;
			end
		endcase
	end

endmodule

FILE: hdl/a64eu_queue.sv
`timescale 1ns / 1ps
// two-entry queue of decoded instructions between front and back
// depends on a64eu_pkg
module a64eu_queue import a64eu_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  dec_t push_dec,
	input  logic pop,
	output logic full,
	output logic head_valid,
	output dec_t head
);

	dec_t       ent_q [2];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] cnt_q;

	assign full       = (cnt_q == 2'd2);
	assign head_valid = (cnt_q != 2'd0);
	assign head       = ent_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wptr_q] <= push_dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= ~wptr_q;
			end
			if (pop) begin
				rptr_q <= ~rptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

FILE: hdl/a64eu_back.sv
`timescale 1ns / 1ps
// back end: register file read, execute, multiply sequencer, result register
// depends on a64eu_pkg
module a64eu_back import a64eu_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        head_valid,
	input  dec_t        head,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [4:0]  dest_index,
	output logic        write_enable,
	output logic [63:0] write_value,
	output logic        flag_n,
	output logic        flag_z,
	output logic        flag_c,
	output logic        flag_v,
	output logic [63:0] next_pc,
	output logic        fault
);

	localparam logic [2:0] MSTEP_LAST = 3'd5;

	typedef struct packed {
		logic [63:0] r;
		logic [3:0]  f;
	} addres_t;

	function automatic addres_t add_flags(input logic [63:0] x, input logic [63:0] y,
		input logic cin, input logic sf);
		logic [64:0] s64;
		logic [32:0] s32;
		addres_t     o;
		logic [63:0] ov;
		s64 = {1'b0, x} + {1'b0, y} + {64'd0, cin};
		s32 = {1'b0, x[31:0]} + {1'b0, y[31:0]} + {32'd0, cin};
		if (sf) begin
			o.r = s64[63:0];
			ov  = ~(x ^ y) & (x ^ o.r);
			o.f = {o.r[63], o.r == 64'd0, s64[64], ov[63]};
		end else begin
			o.r = {32'd0, s32[31:0]};
			ov  = ~(x ^ y) & (x ^ o.r);
			o.f = {o.r[31], o.r == 64'd0, s32[32], ov[31]};
		end
		return o;
	endfunction

	function automatic logic [63:0] shift_val(input logic [63:0] v, input logic [1:0] st,
		input logic [5:0] a, input logic sf);
		logic [63:0] r;
		logic [31:0] w;
		logic [31:0] w2;
		logic [4:0]  a5;
		w  = v[31:0];
		a5 = a[4:0];
		w2 = w;
		r  = v;
		if (sf) begin
			unique case (st)
				2'd0:    r = v << a;
				2'd1:    r = v >> a;
				2'd2:    r = $signed(v) >>> a;
				default: r = (v >> a) | (v << (7'd64 - {1'b0, a}));
			endcase
		end else begin
			unique case (st)
				2'd0:    w2 = w << a5;
				2'd1:    w2 = w >> a5;
				2'd2:    w2 = $signed(w) >>> a5;
				default: w2 = (w >> a5) | (w << (6'd32 - {1'b0, a5}));
			endcase
			r = {32'd0, w2};
		end
		return r;
	endfunction

	function automatic logic cond_holds(input logic [3:0] cond, input logic [3:0] f);
		logic r;
		unique case (cond[3:1])
			3'd0:    r = f[2];
			3'd1:    r = f[1];
			3'd2:    r = f[3];
			3'd3:    r = f[0];
			3'd4:    r = f[1] && !f[2];
			3'd5:    r = (f[3] == f[0]);
			3'd6:    r = (f[3] == f[0]) && !f[2];
			default: r = 1'b1;
		endcase
		if (cond[3:1] != 3'd7 && cond[0]) begin
			r = !r;
		end
		return r;
	endfunction

	// register file, valid bits stand for the all-zero reset
	logic [63:0] mem [31];
	logic [30:0] rf_valid_q;
	logic [63:0] d0_q;
	logic [63:0] d1_q;

	logic        s1_valid_q;
	dec_t        s1_q;
	logic [3:0]  flags_q;
	logic [63:0] pc_q;

	logic [2:0]  mstep_q;
	logic [63:0] ma_q;
	logic [63:0] mb_q;
	logic [63:0] mra_q;
	logic [63:0] prod_q;
	logic [63:0] acc_q;

	logic        out_valid_q;
	logic        out_free;
	logic        is_mul;
	logic        e_done;
	logic        mul_adv;
	logic        rd0_en;
	logic [4:0]  addr0;
	logic        wen;

	logic        sf;
	logic [63:0] msk;
	logic [63:0] x;
	logic [63:0] ysh;
	logic [63:0] y;
	logic [63:0] imm;
	logic [63:0] opnd;
	logic [5:0]  wsh;
	addres_t     ad;
	logic [63:0] res;
	logic        wr;
	logic        flt;
	logic [3:0]  fl_n;
	logic [63:0] pc_n;

	assign out_free = !out_valid_q || !out_stall;
	assign is_mul   = (s1_q.op == OP_MUL);
	assign e_done   = s1_valid_q && out_free && (!is_mul || mstep_q == MSTEP_LAST);
	assign mul_adv  = s1_valid_q && is_mul && (mstep_q != MSTEP_LAST);
	assign pop      = head_valid && (!s1_valid_q || e_done);
	// step zero of a multiply re-reads port 0 for the addend
	assign rd0_en   = pop || (mul_adv && mstep_q == 3'd0);
	assign addr0    = pop ? head.ra0 : s1_q.iw[14:10];
	assign wen      = e_done && wr;

	always_ff @(posedge clk) begin
		if (wen) begin
			mem[s1_q.iw[4:0]] <= res;
		end
		if (rd0_en) begin
			if (wen && s1_q.iw[4:0] == addr0) begin
				d0_q <= res;
			end else if (addr0 == ZERO_REG || !rf_valid_q[addr0]) begin
				d0_q <= 64'd0;
			end else begin
				d0_q <= mem[addr0];
			end
		end
		if (pop) begin
			if (wen && s1_q.iw[4:0] == head.ra1) begin
				d1_q <= res;
			end else if (head.ra1 == ZERO_REG || !rf_valid_q[head.ra1]) begin
				d1_q <= 64'd0;
			end else begin
				d1_q <= mem[head.ra1];
			end
		end
		if (pop) begin
			s1_q <= head;
		end
	end

	// multiply: low 64 bits from three 32x32 partial products
	always_ff @(posedge clk) begin
		if (mul_adv) begin
			unique case (mstep_q)
				3'd0: begin
					ma_q <= x;
					mb_q <= sf ? d1_q : {32'd0, d1_q[31:0]};
				end
				3'd1: begin
					mra_q  <= x;
					prod_q <= ma_q[31:0] * mb_q[31:0];
				end
				3'd2: begin
					acc_q  <= prod_q;
					prod_q <= ma_q[31:0] * mb_q[63:32];
				end
				3'd3: begin
					acc_q  <= acc_q + {prod_q[31:0], 32'd0};
					prod_q <= ma_q[63:32] * mb_q[31:0];
				end
				default: begin
					acc_q <= acc_q + {prod_q[31:0], 32'd0};
				end
			endcase
		end
	end

	always_comb begin
		sf   = s1_q.iw[31];
		msk  = sf ? {64{1'b1}} : {32'd0, {32{1'b1}}};
		x    = d0_q & msk;
		ysh  = shift_val(d1_q & msk, s1_q.iw[23:22], s1_q.iw[15:10], sf);
		y    = ysh;
		imm  = {52'd0, s1_q.iw[21:10]};
		wsh  = {s1_q.iw[22:21], 4'd0};
		opnd = {48'd0, s1_q.iw[20:5]} << wsh;
		ad   = add_flags(64'd0, 64'd0, 1'b0, sf);
		res  = 64'd0;
		wr   = 1'b0;
		flt  = 1'b0;
		fl_n = flags_q;
		pc_n = pc_q + 64'd4;
		unique case (s1_q.op)
			OP_NOP: begin
			end
			OP_ADDI: begin
				if (s1_q.iw[22]) begin
					imm = imm << 12;
				end
				ad  = add_flags(x, s1_q.iw[30] ? ~imm : imm, s1_q.iw[30], sf);
				res = ad.r;
				if (s1_q.iw[29]) begin
					fl_n = ad.f;
				end
				wr = 1'b1;
			end
			OP_MOVW: begin
				unique case (s1_q.iw[30:29])
					2'b00:   res = ~opnd;
					2'b10:   res = opnd;
					default: res = (d0_q & ~(64'hffff << wsh)) | opnd;
				endcase
				wr = 1'b1;
			end
			OP_LOGR: begin
				if (s1_q.iw[21]) begin
					y = ~ysh & msk;
				end
				unique case (s1_q.iw[30:29])
					2'b01:   res = x | y;
					2'b10:   res = x ^ y;
					default: res = x & y;
				endcase
				if (s1_q.iw[30:29] == 2'b11) begin
					fl_n = {sf ? res[63] : res[31], (res & msk) == 64'd0, 2'b00};
				end
				wr = 1'b1;
			end
			OP_ADDR: begin
				ad  = add_flags(x, s1_q.iw[30] ? ~ysh : ysh, s1_q.iw[30], sf);
				res = ad.r;
				if (s1_q.iw[29]) begin
					fl_n = ad.f;
				end
				wr = 1'b1;
			end
			OP_MUL: begin
				res = s1_q.iw[15] ? (mra_q - acc_q) : (mra_q + acc_q);
				wr  = 1'b1;
			end
			OP_B: begin
				pc_n = pc_q + {{36{s1_q.iw[25]}}, s1_q.iw[25:0], 2'b00};
			end
			OP_BR: begin
				pc_n = d0_q;
			end
			OP_BCOND: begin
				if (cond_holds(s1_q.iw[3:0], flags_q)) begin
					pc_n = pc_q + {{43{s1_q.iw[23]}}, s1_q.iw[23:5], 2'b00};
				end
			end
			default: begin
				flt  = 1'b1;
				pc_n = pc_q;
			end
		endcase
		res = res & msk;
		if (s1_q.iw[4:0] == ZERO_REG) begin
			wr = 1'b0;
		end
		if (!wr) begin
			res = 64'd0;
		end
	end

	always_ff @(posedge clk) begin
		if (e_done) begin
			dest_index   <= wr ? s1_q.iw[4:0] : 5'd0;
			write_enable <= wr;
			write_value  <= res;
			{flag_n, flag_z, flag_c, flag_v} <= fl_n;
			next_pc      <= pc_n;
			fault        <= flt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rf_valid_q  <= '0;
			s1_valid_q  <= 1'b0;
			flags_q     <= 4'd0;
			pc_q        <= 64'd0;
			mstep_q     <= 3'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (wen) begin
				rf_valid_q[s1_q.iw[4:0]] <= 1'b1;
			end
			if (pop) begin
				s1_valid_q <= 1'b1;
			end else if (e_done) begin
				s1_valid_q <= 1'b0;
			end
			if (e_done) begin
				flags_q <= fl_n;
				pc_q    <= pc_n;
				mstep_q <= 3'd0;
			end else if (mul_adv) begin
				mstep_q <= mstep_q + 3'd1;
			end
			if (e_done) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

FILE: hdl/aarch64_subset_execute_unit.sv
`timescale 1ns / 1ps
// top level of the a64 subset execute unit: front, queue and back joined
// depends on a64eu_pkg, a64eu_front, a64eu_queue, a64eu_back
//
// usage
//  - input channel: in_valid/in_stall carry kind and instruction_word, one
//    instruction per beat; output channel: out_valid/out_stall carry one
//    result beat per instruction, in order
//  - the front classifies each word and pushes it into a two-entry queue;
//    in_stall rises only when that queue is full
//  - the back reads the register file (registered read, write bypass),
//    executes from those registered operands and loads the output register
//  - path: input beat, queue entry, operand registers, output register;
//    multiply-add also steps through a sequencer of 32x32 products
//  - throughput: one instruction per cycle while out_stall is low, set by
//    the single execute stage, which multiply-add holds through its steps
//  - a stalled output holds its beat while the back and queue keep filling
//  - reset clears registers (via valid bits), flags, pc and all pipeline
//    valids; no clearing pass is needed
module aarch64_subset_execute_unit import a64eu_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  kind,
	input  logic [31:0] instruction_word,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [4:0]  dest_index,
	output logic        write_enable,
	output logic [63:0] write_value,
	output logic        flag_n,
	output logic        flag_z,
	output logic        flag_c,
	output logic        flag_v,
	output logic [63:0] next_pc,
	output logic        fault
);

	// front to queue
	logic push;
	dec_t push_dec;
	logic q_full;
	// queue to back
	logic head_valid;
	dec_t head;
	logic pop;

	a64eu_front u_front (
		.valid            (in_valid),
		.kind             (kind),
		.instruction_word (instruction_word),
		.q_full           (q_full),
		.stall            (in_stall),
		.push             (push),
		.dec              (push_dec)
	);

	a64eu_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_dec   (push_dec),
		.pop        (pop),
		.full       (q_full),
		.head_valid (head_valid),
		.head       (head)
	);

	a64eu_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head         (head),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.dest_index   (dest_index),
		.write_enable (write_enable),
		.write_value  (write_value),
		.flag_n       (flag_n),
		.flag_z       (flag_z),
		.flag_c       (flag_c),
		.flag_v       (flag_v),
		.next_pc      (next_pc),
		.fault        (fault)
	);

`ifndef SYNTHESIS
	// a faulting beat never writes a register
	a_fault_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && fault |-> !write_enable && write_value == 64'd0 && dest_index == 5'd0)
		else $error("fault beat carries a register write");

	// the zero register is never reported as written
	a_no_zero_reg_write: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && write_enable |-> dest_index != ZERO_REG)
		else $error("write reported to register thirty-one");

	// queue never pops while empty
	a_pop_needs_head: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("queue popped while empty");
`endif

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
// self-checking bench for aarch64_subset_execute_unit: directed and random instruction beats
// depends on a64eu_pkg and the execute unit rtl; predicts each result beat in place
module tb_top;
	import a64eu_pkg::*;

	typedef struct {
		logic [1:0]  k;
		logic [31:0] iw;
		bit          drain; // hold off until every result is back
	} insn_t;

	typedef struct packed {
		logic [4:0]  dest;
		logic        we;
		logic [63:0] val;
		logic [3:0]  nzcv;
		logic [63:0] pc;
		logic        flt;
	} result_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  kind;
	logic [31:0] instruction_word;
	logic        out_valid;
	logic        out_stall;
	logic [4:0]  dest_index;
	logic        write_enable;
	logic [63:0] write_value;
	logic        flag_n, flag_z, flag_c, flag_v;
	logic [63:0] next_pc;
	logic        fault;

	aarch64_subset_execute_unit i_dut (.*);

	// architectural state as the bench sees it
	logic [63:0] gpr [31];
	logic [3:0]  arch_nzcv;
	logic [63:0] arch_pc;

	insn_t   pending_insns[$];
	result_t expected_results[$];
	int      error_count = 0;
	int      idle_cycles = 0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// ---------------------------------------------------------------
	// predictor
	// ---------------------------------------------------------------
	function automatic logic [63:0] reg_read(logic [4:0] i);
		return (i == ZERO_REG) ? 64'd0 : gpr[i];
	endfunction

	// x + y + cin at 32 or 64 bits, arm nzcv out
	function automatic logic [63:0] add_nzcv(logic [63:0] x, logic [63:0] y, logic cin,
		logic sf, output logic [3:0] f);
		logic [64:0] s64;
		logic [32:0] s32;
		logic [63:0] r;
		logic [63:0] ov;
		if (sf) begin
			s64 = {1'b0, x} + {1'b0, y} + {64'd0, cin};
			r = s64[63:0];
			ov = (~(x ^ y)) & (x ^ r);
			f = {r[63], r == 64'd0, s64[64], ov[63]};
		end else begin
			s32 = {1'b0, x[31:0]} + {1'b0, y[31:0]} + {32'd0, cin};
			r = {32'd0, s32[31:0]};
			ov = (~(x ^ y)) & (x ^ r);
			f = {r[31], r == 64'd0, s32[32], ov[31]};
		end
		return r;
	endfunction

	function automatic logic [63:0] shift_operand(logic [63:0] x, logic [1:0] st,
		logic [5:0] amt, logic sf);
		logic [63:0] mask, sx;
		mask = sf ? '1 : 64'hffff_ffff;
		x &= mask;
		if (amt == 0)
			return x;
		case (st)
			2'd0: return (x << amt) & mask;
			2'd1: return x >> amt;
			2'd2: begin
				sx = sf ? x : {{32{x[31]}}, x[31:0]};
				return $unsigned($signed(sx) >>> amt) & mask;
			end
			default: return sf ? ((x >> amt) | (x << (64 - amt)))
				: (((x >> amt) | (x << (32 - amt))) & mask);
		endcase
	endfunction

	function automatic logic cond_passes(logic [3:0] c, logic [3:0] f);
		logic r;
		case (c[3:1])
			3'd0: r = f[2];
			3'd1: r = f[1];
			3'd2: r = f[3];
			3'd3: r = f[0];
			3'd4: r = f[1] && !f[2];
			3'd5: r = (f[3] == f[0]);
			3'd6: r = (f[3] == f[0]) && !f[2];
			default: return 1'b1; // al, both encodings
		endcase
		return c[0] ? !r : r;
	endfunction

	// executes one beat on the bench state and returns the result it must produce
	function automatic result_t execute_insn(logic [1:0] k, logic [31:0] iw);
		result_t     o;
		logic        sf, wr, flt;
		logic [63:0] mask, x, y, imm, res, npc, prod;
		logic [3:0]  fl, nf;
		logic [4:0]  rd, rn, rm;
		logic [1:0]  opc, hw, st;
		logic [5:0]  amt;
		sf   = iw[31];
		mask = sf ? '1 : 64'hffff_ffff;
		opc  = iw[30:29];
		rd   = iw[4:0];
		rn   = iw[9:5];
		rm   = iw[20:16];
		fl   = arch_nzcv;
		npc  = arch_pc + 64'd4;
		res  = '0;
		wr   = 1'b0;
		flt  = 1'b0;
		case (k)
			KIND_DPI: begin
				if (iw[25:23] == OPI_ARITH) begin
					imm = {52'd0, iw[21:10]};
					if (iw[22])
						imm <<= 12;
					x = reg_read(rn) & mask;
					res = opc[1] ? add_nzcv(x, ~imm, 1'b1, sf, nf)
						: add_nzcv(x, imm, 1'b0, sf, nf);
					if (opc[0])
						fl = nf;
					wr = 1'b1;
				end else if (iw[25:23] == OPI_WIDE) begin
					hw  = iw[22:21];
					imm = {48'd0, iw[20:5]} << (hw * 16);
					if (opc == 2'd1 || (!sf && hw[1])) begin
						flt = 1'b1;
					end else begin
						case (opc)
							2'd0: res = ~imm;
							2'd2: res = imm;
							default: res = (reg_read(rd) & ~(64'hffff << (hw * 16))) | imm;
						endcase
						wr = 1'b1;
					end
				end else begin
					flt = 1'b1;
				end
			end
			KIND_DPR: begin
				if (!iw[28]) begin
					st  = iw[23:22];
					amt = iw[15:10];
					if ((!sf && amt[5]) || (iw[24] && iw[21]) || (iw[24] && st == 2'd3)) begin
						flt = 1'b1;
					end else begin
						x = reg_read(rn) & mask;
						y = shift_operand(reg_read(rm), st, amt, sf);
						if (!iw[24]) begin
							if (iw[21])
								y = ~y & mask;
							case (opc)
								2'd1: res = x | y;
								2'd2: res = x ^ y;
								default: res = x & y;
							endcase
							if (opc == 2'd3)
								fl = {sf ? res[63] : res[31], res == 0, 2'b00};
						end else begin
							res = opc[1] ? add_nzcv(x, ~y, 1'b1, sf, nf)
								: add_nzcv(x, y, 1'b0, sf, nf);
							if (opc[0])
								fl = nf;
						end
						wr = 1'b1;
					end
				end else if (iw[24:21] == MUL_OPR) begin
					prod = (reg_read(rn) & mask) * (reg_read(rm) & mask);
					x = reg_read(iw[14:10]) & mask;
					res = iw[15] ? x - prod : x + prod;
					wr = 1'b1;
				end else begin
					flt = 1'b1;
				end
			end
			KIND_BR: begin
				if (iw[31:26] == BR_UNCOND)
					npc = arch_pc + {{36{iw[25]}}, iw[25:0], 2'b00};
				else if (iw[31:26] == BR_REG)
					npc = reg_read(rn);
				else if (iw[31:26] == BR_COND) begin
					if (cond_passes(iw[3:0], arch_nzcv))
						npc = arch_pc + {{43{iw[23]}}, iw[23:5], 2'b00};
				end else
					flt = 1'b1;
			end
			default: ; // nop: pc only
		endcase
		if (flt) begin
			wr  = 1'b0;
			res = '0;
		end else begin
			res &= mask;
			if (rd == ZERO_REG)
				wr = 1'b0;
			if (wr)
				gpr[rd] = res;
			else
				res = '0;
			arch_nzcv = fl;
			arch_pc   = npc;
		end
		o.dest = wr ? rd : 5'd0;
		o.we   = wr;
		o.val  = res;
		o.nzcv = arch_nzcv;
		o.pc   = arch_pc;
		o.flt  = flt;
		return o;
	endfunction

	// ---------------------------------------------------------------
	// encoders
	// ---------------------------------------------------------------
	function automatic insn_t mk(logic [1:0] k, logic [31:0] iw);
		insn_t t;
		t.k = k;
		t.iw = iw;
		t.drain = 1'b0;
		return t;
	endfunction

	function automatic insn_t enc_addi(logic sf, logic op, logic s, logic sh, logic [11:0] imm,
		logic [4:0] rn, logic [4:0] rd);
		return mk(KIND_DPI, {sf, op, s, 3'b100, OPI_ARITH, sh, imm, rn, rd});
	endfunction

	function automatic insn_t enc_movw(logic sf, logic [1:0] opc, logic [1:0] hw,
		logic [15:0] imm, logic [4:0] rd);
		return mk(KIND_DPI, {sf, opc, 3'b100, OPI_WIDE, hw, imm, rd});
	endfunction

	function automatic insn_t enc_logr(logic sf, logic [1:0] opc, logic [1:0] st, logic n,
		logic [4:0] rm, logic [5:0] amt, logic [4:0] rn, logic [4:0] rd);
		return mk(KIND_DPR, {sf, opc, 5'b01010, st, n, rm, amt, rn, rd});
	endfunction

	function automatic insn_t enc_addr(logic sf, logic [1:0] opc, logic [1:0] st,
		logic [4:0] rm, logic [5:0] amt, logic [4:0] rn, logic [4:0] rd);
		return mk(KIND_DPR, {sf, opc, 5'b01011, st, 1'b0, rm, amt, rn, rd});
	endfunction

	function automatic insn_t enc_mul(logic sf, logic sub, logic [4:0] rm, logic [4:0] ra,
		logic [4:0] rn, logic [4:0] rd);
		return mk(KIND_DPR, {sf, 2'b00, 1'b1, 3'b101, MUL_OPR, rm, sub, ra, rn, rd});
	endfunction

	function automatic insn_t enc_b(logic [25:0] off);
		return mk(KIND_BR, {BR_UNCOND, off});
	endfunction

	function automatic insn_t enc_br(logic [4:0] rn);
		return mk(KIND_BR, {BR_REG, 5'b10000, 5'b11111, 6'd0, rn, 5'd0});
	endfunction

	function automatic insn_t enc_bcond(logic [18:0] off, logic [3:0] c);
		return mk(KIND_BR, {BR_COND, 2'b00, off, 1'b0, c});
	endfunction

	// register numbers cluster low so results feed later operands
	function automatic logic [4:0] pick_reg();
		return ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(0, 7));
	endfunction

	function automatic insn_t random_insn();
		int          sel;
		logic        sf;
		logic [1:0]  st;
		logic [5:0]  amt;
		logic [11:0] imm12;
		sel = $urandom_range(0, 99);
		sf  = 1'($urandom_range(0, 1));
		st  = 2'($urandom_range(0, 3));
		amt = sf ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, 31));
		if ($urandom_range(0, 7) == 0)
			amt = sf ? 6'd0 : 6'(($urandom_range(0, 1) == 0) ? 0 : 31);
		imm12 = ($urandom_range(0, 7) == 0) ? 12'hfff : 12'($urandom);
		if (sel < 15)
			return enc_addi(sf, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)), imm12, pick_reg(), pick_reg());
		else if (sel < 27)
			return enc_movw(sf, ($urandom_range(0, 2) == 0) ? 2'd0 : 2'($urandom_range(2, 3)),
				sf ? 2'($urandom_range(0, 3)) : 2'($urandom_range(0, 1)), 16'($urandom),
				pick_reg());
		else if (sel < 42)
			return enc_logr(sf, 2'($urandom_range(0, 3)), st, 1'($urandom_range(0, 1)),
				pick_reg(), amt, pick_reg(), pick_reg());
		else if (sel < 57)
			return enc_addr(sf, 2'($urandom_range(0, 3)), 2'($urandom_range(0, 2)), pick_reg(),
				amt, pick_reg(), pick_reg());
		else if (sel < 67)
			return enc_mul(sf, 1'($urandom_range(0, 1)), pick_reg(), pick_reg(), pick_reg(),
				pick_reg());
		else if (sel < 72)
			return enc_b(26'($urandom));
		else if (sel < 75)
			return enc_br(pick_reg());
		else if (sel < 84)
			return enc_bcond(19'($urandom), 4'($urandom));
		else if (sel < 88)
			return mk(KIND_NOP, $urandom);
		else
			return mk(2'($urandom_range(0, 3)), $urandom); // noise, mostly faults
	endfunction

	// ---------------------------------------------------------------
	// stimulus
	// ---------------------------------------------------------------
	initial begin
		insn_t t;
		arst_n = 1'b0;
		for (int i = 0; i < 31; i++)
			gpr[i] = '0;
		arch_nzcv = '0;
		arch_pc   = '0;

		// directed: field extremes, every class, each fault kind
		pending_insns.push_back(enc_addi(1, 0, 0, 0, 12'hfff, 31, 1));
		pending_insns.push_back(enc_addi(0, 1, 1, 0, 12'd1, 31, 2)); // borrow, negative
		pending_insns.push_back(enc_addi(1, 0, 1, 1, 12'hfff, 1, 3));
		pending_insns.push_back(enc_movw(1, 2'd2, 2'd3, 16'hffff, 4));
		pending_insns.push_back(enc_movw(1, 2'd0, 2'd0, 16'h0, 5)); // all ones
		pending_insns.push_back(enc_movw(0, 2'd3, 2'd1, 16'h1234, 6));
		pending_insns.push_back(enc_movw(1, 2'd1, 2'd0, 16'h1, 7)); // bad opc
		pending_insns.push_back(enc_movw(0, 2'd2, 2'd2, 16'h1, 7)); // hw too big at 32 bits
		pending_insns.push_back(mk(KIND_DPI, 32'h0));               // bad immediate class
		pending_insns.push_back(enc_logr(1, 2'd1, 2'd1, 1, 5, 6'd63, 1, 8));
		pending_insns.push_back(enc_logr(0, 2'd3, 2'd3, 0, 4, 6'd0, 2, 9)); // ands, ror by zero
		pending_insns.push_back(enc_addr(1, 2'd1, 2'd0, 5, 6'd0, 5, 10));   // carry out
		pending_insns.push_back(enc_addr(0, 2'd3, 2'd2, 4, 6'd31, 2, 11));
		pending_insns.push_back(enc_logr(0, 2'd0, 2'd0, 0, 1, 6'd32, 1, 12)); // shift too far
		pending_insns.push_back(enc_addr(1, 2'd0, 2'd3, 1, 6'd1, 1, 12));     // ror on add
		t = enc_addr(1, 2'd0, 2'd0, 1, 6'd0, 1, 12);
		t.iw[21] = 1'b1;
		pending_insns.push_back(t);                                            // b24 and b21
		t = enc_mul(1, 0, 1, 1, 1, 12);
		t.iw[22] = 1'b1;
		pending_insns.push_back(t);                                            // bad mul op
		pending_insns.push_back(enc_mul(1, 0, 5, 1, 4, 13));
		pending_insns.push_back(enc_mul(0, 1, 4, 31, 5, 14));
		pending_insns.push_back(enc_b(26'h2000000)); // back past zero, wraps
		pending_insns.push_back(enc_br(5));
		pending_insns.push_back(enc_bcond(19'h7ffff, 4'he));
		pending_insns.push_back(enc_bcond(19'h3ffff, 4'hf));
		pending_insns.push_back(enc_bcond(19'h1, 4'h0));
		pending_insns.push_back(mk(KIND_BR, 32'h0));       // bad branch
		pending_insns.push_back(mk(KIND_NOP, 32'hffff_ffff));
		pending_insns.push_back(enc_addi(1, 1, 1, 0, 12'h0, 1, 31)); // flags only, no write

		for (int i = 0; i < 1950; i++) begin
			t = random_insn();
			t.drain = (i % 400 == 200);
			pending_insns.push_back(t);
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_insns.size() != 0 || in_valid || expected_results.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (error_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// ---------------------------------------------------------------
	// driver: bursts and gaps, predicts on every accepted beat
	// ---------------------------------------------------------------
	int burst_left = 0;
	int gap_left = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			kind <= KIND_NOP;
			instruction_word <= '0;
		end else begin
			if (in_valid && !in_stall)
				expected_results.push_back(execute_insn(kind, instruction_word));
			if (!in_valid || !in_stall) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (pending_insns.size() == 0 ||
					(pending_insns[0].drain && expected_results.size() != 0)) begin
					in_valid <= 1'b0;
				end else begin
					in_valid <= 1'b1;
					kind <= pending_insns[0].k;
					instruction_word <= pending_insns[0].iw;
					pending_insns[0].drain = 1'b0;
					void'(pending_insns.pop_front());
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(20, 80)
							: $urandom_range(1, 8);
						gap_left = $urandom_range(0, 4);
					end
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// monitor: own stall pattern, checks each result beat
	// ---------------------------------------------------------------
	int stall_mode = 0;
	int stall_left = 0;

	task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
		if (exp_v !== act_v) begin
			error_count++;
			$display("%0t mismatch %s: expected %h actual %h", $time, name, exp_v, act_v);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t e;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					error_count++;
					$display("%0t unexpected result beat", $time);
				end else begin
					e = expected_results.pop_front();
					check_field("dest_index", e.dest, dest_index);
					check_field("write_enable", e.we, write_enable);
					check_field("write_value", e.val, write_value);
					check_field("flag_n", e.nzcv[3], flag_n);
					check_field("flag_z", e.nzcv[2], flag_z);
					check_field("flag_c", e.nzcv[1], flag_c);
					check_field("flag_v", e.nzcv[0], flag_v);
					check_field("next_pc", e.pc, next_pc);
					check_field("fault", e.flt, fault);
				end
			end
			if (stall_left == 0) begin
				stall_mode = $urandom_range(0, 2);
				stall_left = $urandom_range(10, 60);
			end else begin
				stall_left--;
			end
			case (stall_mode)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 9) < 3);
				default: out_stall <= ($urandom_range(0, 9) < 7);
			endcase
		end
	end

	// watchdog on cycles with no beat on either channel
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 5000) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

endmodule
